FILE: rtl/dct_pkg.sv
package dct_pkg;

   // Operation carried by each input item.
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_ACK   = 2'd3
   } action_type;

   // Register map.
   localparam logic [2:0] REG_T0_LOW  = 3'd0;
   localparam logic [2:0] REG_T0_HIGH = 3'd1;
   localparam logic [2:0] REG_T1_LOW  = 3'd2;
   localparam logic [2:0] REG_T1_HIGH = 3'd3;
   localparam logic [2:0] REG_MODE    = 3'd4;
   localparam logic [2:0] REG_CONTROL = 3'd5;
   localparam logic [2:0] REG_IRQ_EN  = 3'd6;

   // Timer mode codes; all other codes hold the timer still.
   localparam logic [2:0] MODE_COUNT16 = 3'd1;
   localparam logic [2:0] MODE_RELOAD  = 3'd2;
   localparam logic [2:0] MODE_SPLIT   = 3'd3;

   // Field positions in the mode and control words.
   localparam int T0_MODE_LSB = 0;
   localparam int T1_MODE_LSB = 4;
   localparam int T0_RUN_BIT  = 4;
   localparam int T1_RUN_BIT  = 6;

   // Count registers of one timer.
   typedef struct packed {
      logic [7:0] low;
      logic [7:0] high;
   } timer_count_type;

   // Next count and overflow from one timer step.
   typedef struct packed {
      timer_count_type count;
      logic            overflow;
   } timer_step_type;

endpackage

FILE: rtl/dual_timer_counter_unit.sv
// Two byte-pair timers behind a byte-wide register map. Each input item is a
// tick, a register write, a register read or an interrupt acknowledge, and
// produces exactly one result item holding the read byte (zero unless the
// item was a read) and both pending flags as they stand after the item. The
// unit takes one item per clock cycle when the output is not stalled; an item
// passes an input register and updates the timer state as it moves on to the
// result register, and a stalled output holds it in the input register. Both
// timers compute their next state combinationally for each item, which sets
// this rate.
module dual_timer_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // reg_index[2:0], write_data[10:3], zero
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[7:0], timer0_pending[8],
                                   // timer1_pending[9], zero
);
   import dct_pkg::*;

   // Input register.
   logic       in_valid_ff;
   action_type in_action_ff;
   logic [2:0] in_index_ff;
   logic [7:0] in_data_ff;

   // Block state.
   timer_count_type t0_ff, t0_in;
   timer_count_type t1_ff, t1_in;
   logic [7:0]      mode_ff, mode_in;
   logic [7:0]      control_ff, control_in;
   logic [1:0]      irq_en_ff, irq_en_in;
   logic [1:0]      pending_ff, pending_in;

   // Result register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_read_ff, rsp_read_in;

   logic           advance;
   timer_step_type t0_step;
   timer_step_type t1_step;

   // The held item moves on when the result register is free or being taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_action_ff <= ACT_TICK;
         in_index_ff  <= 3'd0;
         in_data_ff   <= 8'd0;
      end else if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tuser[1:0]);
         in_index_ff  <= req_tdata[2:0];
         in_data_ff   <= req_tdata[10:3];
      end
   end

   dct_timer u_timer0 (
      .count (t0_ff),
      .mode  (mode_ff[T0_MODE_LSB +: 3]),
      .run   (control_ff[T0_RUN_BIT]),
      .step  (t0_step)
   );

   dct_timer u_timer1 (
      .count (t1_ff),
      .mode  (mode_ff[T1_MODE_LSB +: 3]),
      .run   (control_ff[T1_RUN_BIT]),
      .step  (t1_step)
   );

   // Next state and read byte for the item in the input register.
   always_comb begin
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      mode_in     = mode_ff;
      control_in  = control_ff;
      irq_en_in   = irq_en_ff;
      pending_in  = pending_ff;
      rsp_read_in = 8'd0;
      unique case (in_action_ff)
         ACT_TICK: begin
            t0_in = t0_step.count;
            t1_in = t1_step.count;
            if (t0_step.overflow && irq_en_ff[0]) begin
               pending_in[0] = 1'b1;
            end
            if (t1_step.overflow && irq_en_ff[1]) begin
               pending_in[1] = 1'b1;
            end
         end
         ACT_WRITE: begin
            unique case (in_index_ff)
               REG_T0_LOW:  t0_in.low  = in_data_ff;
               REG_T0_HIGH: t0_in.high = in_data_ff;
               REG_T1_LOW:  t1_in.low  = in_data_ff;
               REG_T1_HIGH: t1_in.high = in_data_ff;
               REG_MODE:    mode_in    = in_data_ff;
               REG_CONTROL: control_in = in_data_ff;
               REG_IRQ_EN:  irq_en_in  = in_data_ff[1:0];
               default:     ;
            endcase
         end
         ACT_READ: begin
            unique case (in_index_ff)
               REG_T0_LOW:  rsp_read_in = t0_ff.low;
               REG_T0_HIGH: rsp_read_in = t0_ff.high;
               REG_T1_LOW:  rsp_read_in = t1_ff.low;
               REG_T1_HIGH: rsp_read_in = t1_ff.high;
               REG_MODE:    rsp_read_in = mode_ff;
               REG_CONTROL: rsp_read_in = control_ff;
               REG_IRQ_EN:  rsp_read_in = {6'd0, irq_en_ff};
               default:     rsp_read_in = 8'd0;
            endcase
         end
         ACT_ACK: begin
            pending_in = 2'b00;
         end
      endcase
   end

   // State is committed as the item moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_ff      <= '0;
         t1_ff      <= '0;
         mode_ff    <= 8'd0;
         control_ff <= 8'd0;
         irq_en_ff  <= 2'b00;
         pending_ff <= 2'b00;
      end else if (advance) begin
         t0_ff      <= t0_in;
         t1_ff      <= t1_in;
         mode_ff    <= mode_in;
         control_ff <= control_in;
         irq_en_ff  <= irq_en_in;
         pending_ff <= pending_in;
      end
   end

   // Result register; pending flags are read back from the state itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_ff <= rsp_read_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, pending_ff, rsp_read_ff};

   // An acknowledged item leaves both flags clear.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_ACK) |=> (pending_ff == 2'b00))
      else $error("pending flags not cleared by acknowledge");

   // Only a read item returns a nonzero byte.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff != ACT_READ) |=> (rsp_read_ff == 8'd0))
      else $error("read byte nonzero for a non-read item");

   // A flag can only be raised while its interrupt is enabled.
   assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff[0]) |-> irq_en_ff[0])
      else $error("timer 0 flag raised while disabled");

   assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff[1]) |-> irq_en_ff[1])
      else $error("timer 1 flag raised while disabled");

endmodule

FILE: rtl/dct_timer.sv
module dct_timer (
   input  dct_pkg::timer_count_type count,
   input  logic [2:0]               mode,
   input  logic                     run,
   output dct_pkg::timer_step_type  step
);
   import dct_pkg::*;

   logic       low_wrap;
   logic       high_wrap;
   logic [7:0] low_inc;
   logic [7:0] high_inc;

   assign low_wrap  = (count.low == 8'hFF);
   assign high_wrap = (count.high == 8'hFF);
   assign low_inc   = count.low + 8'd1;
   assign high_inc  = count.high + 8'd1;

   // One tick in the selected mode; a stopped timer or unused mode holds.
   always_comb begin
      step.count    = count;
      step.overflow = 1'b0;
      if (run) begin
         unique case (mode)
            MODE_COUNT16: begin
               step.count.low = low_inc;
               if (low_wrap) begin
                  step.count.high = high_inc;
               end
               step.overflow = low_wrap && high_wrap;
            end
            MODE_RELOAD: begin
               step.count.low = low_wrap ? count.high : low_inc;
               step.overflow  = low_wrap;
            end
            MODE_SPLIT: begin
               step.count.low  = low_inc;
               step.count.high = high_inc;
               step.overflow   = low_wrap || high_wrap;
            end
            default: begin
               step.count    = count;
               step.overflow = 1'b0;
            end
         endcase
      end
   end

endmodule
